/* hw/rtl/qram_pkg.sv */
// qram_pkg: constants, item types and small helpers of the quad arm and mix core
// no dependencies; imported by every module of the block except qram_fifo
package qram_pkg;

	localparam int unsigned LINK_TIMEOUT_MS   = 100;
	localparam int unsigned STICK_DEADBAND_US = 10;
	localparam int unsigned PULSE_FLOOR_US    = 1000;
	localparam int unsigned PULSE_STOP_US     = 1000;
	localparam int unsigned STICK_MIN_US      = 1000;
	localparam int unsigned STICK_MAX_US      = 2000;
	localparam int unsigned STICK_MID_US      = (STICK_MIN_US + STICK_MAX_US) / 2;
	localparam int unsigned STICK_SPAN_US     = STICK_MAX_US - STICK_MIN_US;
	localparam int unsigned SANE_LOW_US       = 800;
	localparam int unsigned SANE_HIGH_US      = 2200;
	localparam int unsigned THROTTLE_START_US = 1030;
	localparam int unsigned IDLE_PULSE_US     = 1000;
	localparam int unsigned FULL_STICK_US     = 500;

	localparam int unsigned CH_W        = 12;
	localparam int unsigned AGE_W       = 16;
	localparam int unsigned PULSE_W     = 11;
	localparam int unsigned LIMIT_W     = 9;
	localparam int unsigned SIGN_W      = 2;
	localparam int unsigned LEVEL_W     = 12;
	localparam int unsigned STATUS_W    = 2;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 12;

	localparam int unsigned CTR_W   = 11;                   // centred stick, signed
	localparam int unsigned OFS_W   = CTR_W + LIMIT_W + 1;  // stick times limit, signed
	localparam int unsigned BPROD_W = 24;                   // throttle span product, signed
	localparam int unsigned TOTAL_W = 21;                   // base pulse numerator
	localparam int unsigned SUM_W   = 21;                   // biased mix sum
	localparam int unsigned DIFF_W  = 12;                   // biased mix sum in whole us
	localparam int unsigned MOTOR_W = 14;                   // signed motor pulse before clamp
	localparam int unsigned RECIP_W = 22;

	// bias keeps the three-term mix sum non-negative before the reciprocal divide
	localparam int unsigned SUM_BIAS_STEPS = 3 * ((1 << LIMIT_W) - 1) + 1;
	localparam int unsigned SUM_BIAS       = SUM_BIAS_STEPS * FULL_STICK_US;

	localparam int unsigned DIV_FULL_SHIFT = 30;
	localparam longint unsigned DIV_FULL_MUL =
		((64'd1 << DIV_FULL_SHIFT) + FULL_STICK_US - 1) / FULL_STICK_US;
	localparam int unsigned DIV_SPAN_SHIFT = 31;
	localparam longint unsigned DIV_SPAN_MUL =
		((64'd1 << DIV_SPAN_SHIFT) + STICK_SPAN_US - 1) / STICK_SPAN_US;

	localparam int unsigned MID_DEPTH = 2;
	localparam int unsigned OUT_DEPTH = 4;

	localparam logic [CFG_INDEX_W-1:0] REG_MAX_PULSE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RP_GAIN   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_YAW_GAIN  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ROLL_POL  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_PITCH_POL = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_YAW_POL   = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_ARM_LEVEL = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_THR_LOW   = 3'd7;

	localparam logic [STATUS_W-1:0] STATUS_LINK_LOST = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_LOCKED    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_DRIVING   = 2'd2;

	localparam logic signed [SIGN_W-1:0] SIGN_POS  = 2'sb01;
	localparam logic signed [SIGN_W-1:0] SIGN_OFF  = 2'sb00;
	localparam logic signed [SIGN_W-1:0] SIGN_NEG  = 2'sb11;

	typedef struct packed {
		logic [PULSE_W-1:0]        max_pulse;
		logic [LIMIT_W-1:0]        rp_gain;
		logic [LIMIT_W-1:0]        yaw_gain;
		logic signed [SIGN_W-1:0]  roll_pol;
		logic signed [SIGN_W-1:0]  pitch_pol;
		logic signed [SIGN_W-1:0]  yaw_pol;
		logic [LEVEL_W-1:0]        arm_level;
		logic [LEVEL_W-1:0]        thr_low;
	} cfg_t;

	typedef struct packed {
		logic [CH_W-1:0]  roll;
		logic [CH_W-1:0]  pitch;
		logic [CH_W-1:0]  throttle;
		logic [CH_W-1:0]  yaw;
		logic [CH_W-1:0]  arm;
		logic [CH_W-1:0]  aux;
		logic             frame_valid;
		logic [AGE_W-1:0] frame_age;
	} in_item_t;

	typedef struct packed {
		logic                     armed;
		logic                     link;
		logic signed [CTR_W-1:0]  c_roll;
		logic signed [CTR_W-1:0]  c_pitch;
		logic signed [CTR_W-1:0]  c_yaw;
		logic [PULSE_W-1:0]       thr;
	} front_item_t;

	typedef struct packed {
		logic [PULSE_W-1:0]  front_left;
		logic [PULSE_W-1:0]  front_right;
		logic [PULSE_W-1:0]  rear_left;
		logic [PULSE_W-1:0]  rear_right;
		logic [PULSE_W-1:0]  base;
		logic                armed;
		logic                link;
		logic [STATUS_W-1:0] status;
	} out_item_t;

	function automatic logic signed [SIGN_W-1:0] sign_of2(input logic [SIGN_W-1:0] v);
		logic signed [SIGN_W-1:0] s;
		unique case (v)
			2'b01:   s = SIGN_POS;
			2'b00:   s = SIGN_OFF;
			default: s = SIGN_NEG;
		endcase
		return s;
	endfunction

	function automatic logic sane(input logic [CH_W-1:0] ch);
		return (ch >= CH_W'(SANE_LOW_US)) && (ch <= CH_W'(SANE_HIGH_US));
	endfunction

	function automatic logic [PULSE_W-1:0] clamp_stick(input logic [CH_W-1:0] ch);
		logic [PULSE_W-1:0] v;
		if (ch < CH_W'(STICK_MIN_US)) v = PULSE_W'(STICK_MIN_US);
		else if (ch > CH_W'(STICK_MAX_US)) v = PULSE_W'(STICK_MAX_US);
		else v = ch[PULSE_W-1:0];
		return v;
	endfunction

	function automatic logic signed [CTR_W-1:0] centred(input logic [CH_W-1:0] ch);
		logic signed [CTR_W:0] c;
		logic signed [CTR_W:0] m;
		c = $signed({1'b0, clamp_stick(ch)}) - $signed((CTR_W+1)'(STICK_MID_US));
		m = (c < 0) ? -c : c;
		if (m < $signed((CTR_W+1)'(STICK_DEADBAND_US))) return '0;
		return c[CTR_W-1:0];
	endfunction

	function automatic logic signed [OFS_W-1:0] apply_sign(
		input logic signed [OFS_W-1:0] v,
		input logic signed [SIGN_W-1:0] s
	);
		logic signed [OFS_W-1:0] r;
		case (s)
			SIGN_POS: r = v;
			SIGN_NEG: r = -v;
			default:  r = '0;
		endcase
		return r;
	endfunction

endpackage

/* hw/rtl/qram_fifo.sv */
// qram_fifo: small register queue with full, empty and fill count
// uses no package types; the entry type is handed in by the instantiating module
module qram_fifo #(
	parameter int unsigned DEPTH = 2,
	parameter type entry_t = logic
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  entry_t                       wdata,
	input  logic                         pop,
	output entry_t                       rdata,
	output logic                         full,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	entry_t          mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hw/rtl/qram_front.sv */
// qram_front: link check, arm state and stick centring of each accepted beat
// depends on qram_pkg; feeds the middle queue
module qram_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  qram_pkg::in_item_t    in_item,
	input  qram_pkg::cfg_t        cfg,
	input  logic                  q_full,
	output logic                  q_push,
	output qram_pkg::front_item_t q_item
);
	import qram_pkg::*;

	logic armed_q;
	logic armed_d;
	logic link;
	logic sw_on;
	logic accept;

	assign accept = push && !q_full;
	assign q_push = accept;

	always_comb begin
		link = in_item.frame_valid && (in_item.frame_age < AGE_W'(LINK_TIMEOUT_MS))
			&& sane(in_item.roll) && sane(in_item.pitch) && sane(in_item.throttle)
			&& sane(in_item.yaw) && sane(in_item.arm) && sane(in_item.aux);
		sw_on = link && (in_item.arm > cfg.arm_level);
		priority if (!sw_on) begin
			armed_d = 1'b0;
		end else if (!armed_q && (in_item.throttle < cfg.thr_low)) begin
			armed_d = 1'b1;
		end else begin
			armed_d = armed_q;
		end
		q_item.armed   = armed_d;
		q_item.link    = link;
		q_item.c_roll  = centred(in_item.roll);
		q_item.c_pitch = centred(in_item.pitch);
		q_item.c_yaw   = centred(in_item.yaw);
		q_item.thr     = clamp_stick(in_item.throttle);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
		end else if (accept) begin
			armed_q <= armed_d;
		end
	end

endmodule

/* hw/rtl/qram_back.sv */
// qram_back: two-stage mixer pipeline, offsets and throttle span, then reciprocal divides
// depends on qram_pkg; drains the middle queue under credit from the result queue
module qram_back #(
	parameter int unsigned OUT_DEPTH = qram_pkg::OUT_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  qram_pkg::cfg_t                     cfg,
	input  logic                               q_empty,
	input  qram_pkg::front_item_t              q_item,
	output logic                               q_pop,
	input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_count,
	output logic                               out_push,
	output qram_pkg::out_item_t                out_item
);
	import qram_pkg::*;

	localparam int unsigned CW = $clog2(OUT_DEPTH + 1);

	logic                      v_s1;
	logic                      armed_s1;
	logic                      link_s1;
	logic signed [OFS_W-1:0]   r_s1;
	logic signed [OFS_W-1:0]   p_s1;
	logic signed [OFS_W-1:0]   y_s1;
	logic signed [BPROD_W-1:0] bprod_s1;
	logic                      tlow_s1;

	logic                      v_s2;
	logic                      armed_s2;
	logic                      link_s2;
	logic [PULSE_W-1:0]        base_s2;
	logic [DIFF_W-1:0]         d_s2 [4];

	logic [CW+1:0]             occupancy;
	logic signed [OFS_W-1:0]   r_prod;
	logic signed [OFS_W-1:0]   p_prod;
	logic signed [OFS_W-1:0]   y_prod;
	logic signed [BPROD_W-1:0] bprod;
	logic signed [BPROD_W:0]   total_w;
	logic [TOTAL_W-1:0]        total_u;
	logic [TOTAL_W+RECIP_W-1:0] base_prod;
	logic [PULSE_W-1:0]        base_d;
	logic signed [OFS_W+1:0]   x_sum [4];
	logic [SUM_W+RECIP_W-1:0]  d_prod [4];
	logic [DIFF_W-1:0]         d_d [4];
	logic [PULSE_W-1:0]        motor [4];

	function automatic logic [PULSE_W-1:0] motor_of(
		input logic [PULSE_W-1:0] base,
		input logic [DIFF_W-1:0]  d,
		input logic [PULSE_W-1:0] max_pulse
	);
		logic signed [MOTOR_W-1:0] pm;
		logic signed [MOTOR_W-1:0] pc;
		pm = $signed({3'b000, base}) + $signed({2'b00, d})
			- $signed(MOTOR_W'(SUM_BIAS_STEPS));
		if (pm < $signed(MOTOR_W'(PULSE_FLOOR_US))) pc = $signed(MOTOR_W'(PULSE_FLOOR_US));
		else pc = pm;
		if (pc > $signed({3'b000, max_pulse})) pc = $signed({3'b000, max_pulse});
		return pc[PULSE_W-1:0];
	endfunction

	assign occupancy = (CW+2)'(out_count) + (CW+2)'(v_s1) + (CW+2)'(v_s2);
	assign q_pop     = !q_empty && (occupancy < (CW+2)'(OUT_DEPTH));

	// stage one: stick offsets and throttle span product
	always_comb begin
		r_prod = apply_sign(q_item.c_roll * $signed({1'b0, cfg.rp_gain}), cfg.roll_pol);
		p_prod = apply_sign(q_item.c_pitch * $signed({1'b0, cfg.rp_gain}), cfg.pitch_pol);
		y_prod = apply_sign(q_item.c_yaw * $signed({1'b0, cfg.yaw_gain}), cfg.yaw_pol);
		bprod  = $signed({1'b0, q_item.thr - PULSE_W'(STICK_MIN_US)})
			* ($signed({1'b0, cfg.max_pulse}) - $signed((PULSE_W+1)'(PULSE_STOP_US)));
	end

	// stage two: reciprocal divides of base numerator and mix sums
	always_comb begin
		total_w = {bprod_s1[BPROD_W-1], bprod_s1}
			+ (BPROD_W+1)'(PULSE_STOP_US * STICK_SPAN_US);
		total_u   = total_w[BPROD_W] ? '0 : total_w[TOTAL_W-1:0];
		base_prod = (TOTAL_W+RECIP_W)'(total_u) * (TOTAL_W+RECIP_W)'(DIV_SPAN_MUL);
		base_d    = tlow_s1 ? PULSE_W'(PULSE_STOP_US)
			: base_prod[DIV_SPAN_SHIFT +: PULSE_W];
		x_sum[0] = (OFS_W+2)'(p_s1) + (OFS_W+2)'(r_s1) - (OFS_W+2)'(y_s1);
		x_sum[1] = (OFS_W+2)'(p_s1) - (OFS_W+2)'(r_s1) + (OFS_W+2)'(y_s1);
		x_sum[2] = -(OFS_W+2)'(p_s1) + (OFS_W+2)'(r_s1) + (OFS_W+2)'(y_s1);
		x_sum[3] = -(OFS_W+2)'(p_s1) - (OFS_W+2)'(r_s1) - (OFS_W+2)'(y_s1);
		for (int i = 0; i < 4; i++) begin
			d_prod[i] = (SUM_W+RECIP_W)'(SUM_W'(x_sum[i] + (OFS_W+2)'(SUM_BIAS)))
				* (SUM_W+RECIP_W)'(DIV_FULL_MUL);
			d_d[i] = d_prod[i][DIV_FULL_SHIFT +: DIFF_W];
		end
	end

	always_ff @(posedge clk) begin
		armed_s1 <= q_item.armed;
		link_s1  <= q_item.link;
		r_s1     <= r_prod;
		p_s1     <= p_prod;
		y_s1     <= y_prod;
		bprod_s1 <= bprod;
		tlow_s1  <= q_item.thr < PULSE_W'(THROTTLE_START_US);
		armed_s2 <= armed_s1;
		link_s2  <= link_s1;
		base_s2  <= base_d;
		for (int i = 0; i < 4; i++) begin
			d_s2[i] <= d_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= q_pop;
			v_s2 <= v_s1;
		end
	end

	// floor then maximum, disarmed beats idle
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			motor[i] = motor_of(base_s2, d_s2[i], cfg.max_pulse);
		end
		out_push       = v_s2;
		out_item.armed = armed_s2;
		out_item.link  = link_s2;
		if (armed_s2) begin
			out_item.front_left  = motor[0];
			out_item.front_right = motor[1];
			out_item.rear_left   = motor[2];
			out_item.rear_right  = motor[3];
			out_item.base        = base_s2;
			out_item.status      = STATUS_DRIVING;
		end else begin
			out_item.front_left  = PULSE_W'(IDLE_PULSE_US);
			out_item.front_right = PULSE_W'(IDLE_PULSE_US);
			out_item.rear_left   = PULSE_W'(IDLE_PULSE_US);
			out_item.rear_right  = PULSE_W'(IDLE_PULSE_US);
			out_item.base        = PULSE_W'(IDLE_PULSE_US);
			out_item.status      = link_s2 ? STATUS_LOCKED : STATUS_LINK_LOST;
		end
	end

endmodule

/* hw/rtl/quad_rc_arm_and_mix_core.sv */
// quad_rc_arm_and_mix_core: top level with configuration registers and both queues
// depends on qram_pkg, qram_fifo, qram_front and qram_back
//
// One receiver tick is taken per clock while full is low, and results follow in order at one
// per clock while pop keeps up. A tick's result reaches the result ports through the middle
// queue, the mixer pipeline (offset and throttle-span multipliers, then the reciprocal divides)
// and the result queue, where it waits until popped. The mixer draws from the middle queue
// only while the result queue has room for every beat already in the pipeline, so a stalled
// output fills the queues and then raises full. Configuration writes are accepted every cycle
// and take effect on the next tick; write them only while no beats are in flight.
module quad_rc_arm_and_mix_core #(
	parameter int unsigned MID_DEPTH = qram_pkg::MID_DEPTH,
	parameter int unsigned OUT_DEPTH = qram_pkg::OUT_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [qram_pkg::CH_W-1:0]         roll_stick,
	input  logic [qram_pkg::CH_W-1:0]         pitch_stick,
	input  logic [qram_pkg::CH_W-1:0]         throttle_stick,
	input  logic [qram_pkg::CH_W-1:0]         yaw_stick,
	input  logic [qram_pkg::CH_W-1:0]         arm_channel,
	input  logic [qram_pkg::CH_W-1:0]         aux_channel,
	input  logic                              frame_valid,
	input  logic [qram_pkg::AGE_W-1:0]        frame_age_ms,
	output logic                              empty,
	input  logic                              pop,
	output logic [qram_pkg::PULSE_W-1:0]      motor_front_left,
	output logic [qram_pkg::PULSE_W-1:0]      motor_front_right,
	output logic [qram_pkg::PULSE_W-1:0]      motor_rear_left,
	output logic [qram_pkg::PULSE_W-1:0]      motor_rear_right,
	output logic [qram_pkg::PULSE_W-1:0]      base_pulse,
	output logic                              is_armed,
	output logic                              link_ok,
	output logic [qram_pkg::STATUS_W-1:0]     status,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [qram_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [qram_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import qram_pkg::*;

	cfg_t                          cfg_q;
	in_item_t                      in_item;
	front_item_t                   mid_wdata;
	front_item_t                   mid_rdata;
	logic                          mid_push;
	logic                          mid_pop;
	logic                          mid_full;
	logic                          mid_empty;
	logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
	out_item_t                     out_wdata;
	out_item_t                     out_rdata;
	logic                          out_push;
	logic                          out_full;
	logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_pulse <= PULSE_W'(1550);
			cfg_q.rp_gain   <= LIMIT_W'(100);
			cfg_q.yaw_gain  <= '0;
			cfg_q.roll_pol  <= SIGN_POS;
			cfg_q.pitch_pol <= SIGN_POS;
			cfg_q.yaw_pol   <= SIGN_OFF;
			cfg_q.arm_level <= LEVEL_W'(1500);
			cfg_q.thr_low   <= LEVEL_W'(1100);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MAX_PULSE: cfg_q.max_pulse <= cfg_data[PULSE_W-1:0];
				REG_RP_GAIN:   cfg_q.rp_gain   <= cfg_data[LIMIT_W-1:0];
				REG_YAW_GAIN:  cfg_q.yaw_gain  <= cfg_data[LIMIT_W-1:0];
				REG_ROLL_POL:  cfg_q.roll_pol  <= sign_of2(cfg_data[SIGN_W-1:0]);
				REG_PITCH_POL: cfg_q.pitch_pol <= sign_of2(cfg_data[SIGN_W-1:0]);
				REG_YAW_POL:   cfg_q.yaw_pol   <= sign_of2(cfg_data[SIGN_W-1:0]);
				REG_ARM_LEVEL: cfg_q.arm_level <= cfg_data[LEVEL_W-1:0];
				REG_THR_LOW:   cfg_q.thr_low   <= cfg_data[LEVEL_W-1:0];
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	always_comb begin
		in_item.roll        = roll_stick;
		in_item.pitch       = pitch_stick;
		in_item.throttle    = throttle_stick;
		in_item.yaw         = yaw_stick;
		in_item.arm         = arm_channel;
		in_item.aux         = aux_channel;
		in_item.frame_valid = frame_valid;
		in_item.frame_age   = frame_age_ms;
	end

	assign full = mid_full;

	qram_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.in_item (in_item),
		.cfg     (cfg_q),
		.q_full  (mid_full),
		.q_push  (mid_push),
		.q_item  (mid_wdata)
	);

	qram_fifo #(
		.DEPTH   (MID_DEPTH),
		.entry_t (front_item_t)
	) u_mid_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.full   (mid_full),
		.empty  (mid_empty),
		.count  (mid_count)
	);

	qram_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (mid_empty || (mid_count == '0)),
		.q_item    (mid_rdata),
		.q_pop     (mid_pop),
		.out_count (out_count),
		.out_push  (out_push),
		.out_item  (out_wdata)
	);

	qram_fifo #(
		.DEPTH   (OUT_DEPTH),
		.entry_t (out_item_t)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push && !out_full),
		.wdata  (out_wdata),
		.pop    (pop),
		.rdata  (out_rdata),
		.full   (out_full),
		.empty  (empty),
		.count  (out_count)
	);

	always_comb begin
		motor_front_left  = out_rdata.front_left;
		motor_front_right = out_rdata.front_right;
		motor_rear_left   = out_rdata.rear_left;
		motor_rear_right  = out_rdata.rear_right;
		base_pulse        = out_rdata.base;
		is_armed          = out_rdata.armed;
		link_ok           = out_rdata.link;
		status            = out_rdata.status;
	end

endmodule

/* sim/quad_rc_arm_and_mix_core_test.sv */
// quad_rc_arm_and_mix_core_test: self-checking bench for the quad arm and mix core
// drives receiver ticks and register writes, predicts arm state and motor pulses per beat
// depends on qram_pkg and quad_rc_arm_and_mix_core
`timescale 1ns / 100ps

module quad_rc_arm_and_mix_core_test;
	import qram_pkg::*;

	localparam logic [SIGN_W-1:0] SIGN_RAW_MINUS_TWO = 2'b10;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_PER_PHASE = 140;

	typedef enum {SINK_STEADY, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} sink_mode_t;

	typedef struct {
		in_item_t  item;
		bit        known;
		out_item_t result;
	} row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   push;
	logic                   full;
	logic [CH_W-1:0]        roll_stick;
	logic [CH_W-1:0]        pitch_stick;
	logic [CH_W-1:0]        throttle_stick;
	logic [CH_W-1:0]        yaw_stick;
	logic [CH_W-1:0]        arm_channel;
	logic [CH_W-1:0]        aux_channel;
	logic                   frame_valid;
	logic [AGE_W-1:0]       frame_age_ms;
	logic                   empty;
	logic                   pop;
	logic [PULSE_W-1:0]     motor_front_left;
	logic [PULSE_W-1:0]     motor_front_right;
	logic [PULSE_W-1:0]     motor_rear_left;
	logic [PULSE_W-1:0]     motor_rear_right;
	logic [PULSE_W-1:0]     base_pulse;
	logic                   is_armed;
	logic                   link_ok;
	logic [STATUS_W-1:0]    status;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// predictor copy of the registers and the arm flag
	int max_us;
	int mix_us;
	int yaw_us;
	int roll_dir;
	int pitch_dir;
	int yaw_dir;
	int arm_level_us;
	int thr_low_us;
	bit armed_now;

	out_item_t awaited_pulses[$];
	int        mismatch_count;
	int        burst_left;
	bit        hold_req;
	row_t      directed_rows [21];

	quad_rc_arm_and_mix_core u_dut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int direction_of(input logic [SIGN_W-1:0] raw);
		if (raw == SIGN_POS) return 1;
		if (raw == SIGN_OFF) return 0;
		return -1;
	endfunction

	function automatic bit link_channel_ok(input logic [CH_W-1:0] ch);
		return int'(ch) >= int'(SANE_LOW_US) && int'(ch) <= int'(SANE_HIGH_US);
	endfunction

	function automatic longint stick_clamped(input logic [CH_W-1:0] ch);
		longint v;
		v = longint'(ch);
		if (v < longint'(STICK_MIN_US)) v = longint'(STICK_MIN_US);
		if (v > longint'(STICK_MAX_US)) v = longint'(STICK_MAX_US);
		return v;
	endfunction

	function automatic longint stick_offset(input logic [CH_W-1:0] ch);
		longint c;
		c = stick_clamped(ch) - longint'(STICK_MID_US);
		if (c > -longint'(STICK_DEADBAND_US) && c < longint'(STICK_DEADBAND_US)) c = 0;
		return c;
	endfunction

	function automatic logic [PULSE_W-1:0] motor_pulse(input longint sum500);
		longint p;
		if (sum500 < longint'(PULSE_FLOOR_US) * longint'(FULL_STICK_US)) p = longint'(PULSE_FLOOR_US);
		else p = sum500 / longint'(FULL_STICK_US);
		if (p > longint'(max_us)) p = longint'(max_us);
		return p[PULSE_W-1:0];
	endfunction

	function automatic out_item_t known_result(input logic armed, input logic link,
			input logic [STATUS_W-1:0] st);
		out_item_t r;
		r.front_left  = PULSE_W'(IDLE_PULSE_US);
		r.front_right = PULSE_W'(IDLE_PULSE_US);
		r.rear_left   = PULSE_W'(IDLE_PULSE_US);
		r.rear_right  = PULSE_W'(IDLE_PULSE_US);
		r.base        = PULSE_W'(IDLE_PULSE_US);
		r.armed       = armed;
		r.link        = link;
		r.status      = st;
		return r;
	endfunction

	function automatic out_item_t mix_tick(input in_item_t t);
		out_item_t r;
		bit        link;
		longint    thr;
		longint    total;
		longint    base;
		longint    ro;
		longint    pi;
		longint    ya;
		longint    b;
		link = t.frame_valid && int'(t.frame_age) < int'(LINK_TIMEOUT_MS)
			&& link_channel_ok(t.roll) && link_channel_ok(t.pitch)
			&& link_channel_ok(t.throttle) && link_channel_ok(t.yaw)
			&& link_channel_ok(t.arm) && link_channel_ok(t.aux);
		if (!link || !(int'(t.arm) > arm_level_us)) armed_now = 1'b0;
		else if (!armed_now && int'(t.throttle) < thr_low_us) armed_now = 1'b1;
		if (!armed_now) begin
			r = known_result(1'b0, link, link ? STATUS_LOCKED : STATUS_LINK_LOST);
		end else begin
			thr = stick_clamped(t.throttle);
			if (thr < longint'(THROTTLE_START_US)) begin
				base = longint'(PULSE_STOP_US);
			end else begin
				total = longint'(PULSE_STOP_US) * longint'(STICK_SPAN_US)
					+ (thr - longint'(STICK_MIN_US)) * (longint'(max_us) - longint'(PULSE_STOP_US));
				if (total < 0) total = 0;
				base = total / longint'(STICK_SPAN_US);
			end
			ro = roll_dir * stick_offset(t.roll) * mix_us;
			pi = pitch_dir * stick_offset(t.pitch) * mix_us;
			ya = yaw_dir * stick_offset(t.yaw) * yaw_us;
			b = base * longint'(FULL_STICK_US);
			r.front_left  = motor_pulse(b + pi + ro - ya);
			r.front_right = motor_pulse(b + pi - ro + ya);
			r.rear_left   = motor_pulse(b - pi + ro + ya);
			r.rear_right  = motor_pulse(b - pi - ro - ya);
			r.base        = base[PULSE_W-1:0];
			r.armed       = 1'b1;
			r.link        = 1'b1;
			r.status      = STATUS_DRIVING;
		end
		return r;
	endfunction

	function automatic in_item_t tick(input int r, p, th, y, a, x, v, age);
		in_item_t t;
		t.roll        = CH_W'(r);
		t.pitch       = CH_W'(p);
		t.throttle    = CH_W'(th);
		t.yaw         = CH_W'(y);
		t.arm         = CH_W'(a);
		t.aux         = CH_W'(x);
		t.frame_valid = v[0];
		t.frame_age   = AGE_W'(age);
		return t;
	endfunction

	function automatic logic [CH_W-1:0] pick_stick();
		logic [CH_W-1:0] v;
		case ($urandom_range(0, 5))
			0, 1: v = CH_W'($urandom_range(SANE_LOW_US, SANE_HIGH_US));
			2: v = CH_W'($urandom_range(STICK_MIN_US, STICK_MAX_US));
			3: v = CH_W'($urandom_range(STICK_MID_US - 2 * STICK_DEADBAND_US,
				STICK_MID_US + 2 * STICK_DEADBAND_US));
			4: begin
				case ($urandom_range(0, 5))
					0: v = CH_W'(SANE_LOW_US);
					1: v = CH_W'(STICK_MIN_US);
					2: v = CH_W'(THROTTLE_START_US - 1);
					3: v = CH_W'(THROTTLE_START_US);
					4: v = CH_W'(STICK_MAX_US);
					default: v = CH_W'(SANE_HIGH_US);
				endcase
			end
			default: v = CH_W'(STICK_MID_US);
		endcase
		return v;
	endfunction

	function automatic in_item_t random_tick();
		in_item_t        t;
		int              pick;
		int              lo;
		int              hi;
		logic [CH_W-1:0] bad;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			t = tick($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom_range(0, 1), $urandom_range(0, 65535));
			return t;
		end
		t.roll        = pick_stick();
		t.pitch       = pick_stick();
		t.throttle    = pick_stick();
		t.yaw         = pick_stick();
		t.aux         = CH_W'($urandom_range(SANE_LOW_US, SANE_HIGH_US));
		t.frame_valid = 1'b1;
		t.frame_age   = AGE_W'($urandom_range(0, LINK_TIMEOUT_MS - 1));
		lo = arm_level_us + 1;
		if (lo < int'(SANE_LOW_US)) lo = SANE_LOW_US;
		t.arm = (lo <= int'(SANE_HIGH_US)) ? CH_W'($urandom_range(lo, SANE_HIGH_US))
			: CH_W'($urandom_range(SANE_LOW_US, SANE_HIGH_US));
		if (pick >= 20 && pick < 30) begin
			// arming attempt with the throttle low
			hi = thr_low_us - 1;
			if (hi > int'(SANE_HIGH_US)) hi = SANE_HIGH_US;
			if (hi >= int'(SANE_LOW_US)) t.throttle = CH_W'($urandom_range(SANE_LOW_US, hi));
		end else if (pick < 20) begin
			case ($urandom_range(0, 4))
				0: t.frame_valid = 1'b0;
				1: t.frame_age = AGE_W'($urandom_range(LINK_TIMEOUT_MS, 65535));
				2: t.frame_age = AGE_W'(LINK_TIMEOUT_MS);
				3: begin
					hi = (arm_level_us > int'(SANE_HIGH_US)) ? SANE_HIGH_US : arm_level_us;
					t.arm = (hi >= int'(SANE_LOW_US)) ? CH_W'($urandom_range(SANE_LOW_US, hi))
						: CH_W'($urandom_range(0, hi));
				end
				default: begin
					bad = $urandom_range(0, 1) ? CH_W'($urandom_range(0, SANE_LOW_US - 1))
						: CH_W'($urandom_range(SANE_HIGH_US + 1, 4095));
					case ($urandom_range(0, 5))
						0: t.roll = bad;
						1: t.pitch = bad;
						2: t.throttle = bad;
						3: t.yaw = bad;
						4: t.arm = bad;
						default: t.aux = bad;
					endcase
				end
			endcase
		end
		return t;
	endfunction

	task automatic drive_fields(input in_item_t t);
		roll_stick     <= t.roll;
		pitch_stick    <= t.pitch;
		throttle_stick <= t.throttle;
		yaw_stick      <= t.yaw;
		arm_channel    <= t.arm;
		aux_channel    <= t.aux;
		frame_valid    <= t.frame_valid;
		frame_age_ms   <= t.frame_age;
	endtask

	task automatic send_tick(input in_item_t t, input bit known, input out_item_t typed);
		int        gap;
		out_item_t predicted;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				push <= 1'b0;
				drive_fields(random_tick());
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		push <= 1'b1;
		drive_fields(t);
		do @(posedge clk); while (full);
		predicted = mix_tick(t);
		awaited_pulses.push_back(known ? typed : predicted);
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MAX_PULSE: max_us       = int'(data[PULSE_W-1:0]);
			REG_RP_GAIN:   mix_us       = int'(data[LIMIT_W-1:0]);
			REG_YAW_GAIN:  yaw_us       = int'(data[LIMIT_W-1:0]);
			REG_ROLL_POL:  roll_dir     = direction_of(data[SIGN_W-1:0]);
			REG_PITCH_POL: pitch_dir    = direction_of(data[SIGN_W-1:0]);
			REG_YAW_POL:   yaw_dir      = direction_of(data[SIGN_W-1:0]);
			REG_ARM_LEVEL: arm_level_us = int'(data[LEVEL_W-1:0]);
			default:       thr_low_us   = int'(data[LEVEL_W-1:0]);
		endcase
	endtask

	task automatic apply_settings(input int max_p, mix, yaw, rs, ps, ys, arm_lvl, thr_lvl);
		cfg_write(REG_MAX_PULSE, CFG_DATA_W'(max_p));
		cfg_write(REG_RP_GAIN, CFG_DATA_W'(mix));
		cfg_write(REG_YAW_GAIN, CFG_DATA_W'(yaw));
		cfg_write(REG_ROLL_POL, CFG_DATA_W'(rs));
		cfg_write(REG_PITCH_POL, CFG_DATA_W'(ps));
		cfg_write(REG_YAW_POL, CFG_DATA_W'(ys));
		cfg_write(REG_ARM_LEVEL, CFG_DATA_W'(arm_lvl));
		cfg_write(REG_THR_LOW, CFG_DATA_W'(thr_lvl));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (awaited_pulses.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// result side: stall pattern and a long hold-off on request
	initial begin : result_sink
		int         hold_left;
		int         run_left;
		int         cycle_count;
		sink_mode_t mode;
		pop = 1'b0;
		hold_left = 0;
		run_left = 0;
		cycle_count = 0;
		mode = SINK_STEADY;
		forever begin
			@(negedge clk);
			cycle_count++;
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				if (run_left == 0) begin
					mode = sink_mode_t'($urandom_range(0, 3));
					run_left = $urandom_range(4, 64);
				end
				run_left--;
				case (mode)
					SINK_STEADY:  pop <= 1'b1;
					SINK_COIN:    pop <= 1'($urandom_range(0, 1));
					SINK_SPARSE:  pop <= ($urandom_range(0, 4) == 0);
					default:      pop <= (cycle_count % 3 != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (awaited_pulses.size() == 0) begin
				$error("result beat with no expectation waiting");
				mismatch_count++;
			end else begin
				want = awaited_pulses.pop_front();
				check_field("motor_front_left", 16'(want.front_left), 16'(motor_front_left));
				check_field("motor_front_right", 16'(want.front_right), 16'(motor_front_right));
				check_field("motor_rear_left", 16'(want.rear_left), 16'(motor_rear_left));
				check_field("motor_rear_right", 16'(want.rear_right), 16'(motor_rear_right));
				check_field("base_pulse", 16'(want.base), 16'(base_pulse));
				check_field("is_armed", 16'(want.armed), 16'(is_armed));
				check_field("link_ok", 16'(want.link), 16'(link_ok));
				check_field("status", 16'(want.status), 16'(status));
			end
		end
	end

	initial begin
		#3_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		roll_stick = '0;
		pitch_stick = '0;
		throttle_stick = '0;
		yaw_stick = '0;
		arm_channel = '0;
		aux_channel = '0;
		frame_valid = 1'b0;
		frame_age_ms = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_MAX_PULSE;
		cfg_data = '0;
		hold_req = 1'b0;
		burst_left = 0;
		mismatch_count = 0;
		max_us = 1550;
		mix_us = 100;
		yaw_us = 0;
		roll_dir = 1;
		pitch_dir = 1;
		yaw_dir = 0;
		arm_level_us = 1500;
		thr_low_us = 1100;
		armed_now = 1'b0;

		directed_rows = '{
			'{tick(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, known_result(1'b0, 1'b0, STATUS_LINK_LOST)},
			'{tick(4095, 4095, 4095, 4095, 4095, 4095, 1, 65535), 1'b1,
				known_result(1'b0, 1'b0, STATUS_LINK_LOST)},
			'{tick(1500, 1500, 1000, 1500, 1000, 1500, 1, 0), 1'b1,
				known_result(1'b0, 1'b1, STATUS_LOCKED)},
			'{tick(1500, 1500, 1000, 1500, 2000, 1500, 1, 0), 1'b1,
				known_result(1'b1, 1'b1, STATUS_DRIVING)},
			'{tick(1500, 1500, 1029, 1500, 2000, 1500, 1, 99), 1'b1,
				known_result(1'b1, 1'b1, STATUS_DRIVING)},
			'{tick(1500, 1500, 1030, 1500, 2000, 1500, 1, 50), 1'b0, '0},
			'{tick(2000, 1500, 2000, 1500, 2000, 1500, 1, 0), 1'b0, '0},
			'{tick(1000, 2000, 1500, 1500, 2000, 1500, 1, 0), 1'b0, '0},
			'{tick(1509, 1491, 1500, 1500, 2000, 1500, 1, 0), 1'b0, '0},
			'{tick(1510, 1490, 1500, 2000, 2000, 1500, 1, 0), 1'b0, '0},
			'{tick(800, 2200, 1500, 800, 2200, 2200, 1, 0), 1'b0, '0},
			'{tick(1500, 1500, 1500, 1500, 2000, 1500, 1, 100), 1'b1,
				known_result(1'b0, 1'b0, STATUS_LINK_LOST)},
			'{tick(1500, 1500, 1500, 1500, 2000, 1500, 1, 0), 1'b1,
				known_result(1'b0, 1'b1, STATUS_LOCKED)},
			'{tick(1500, 1500, 800, 1500, 2000, 1500, 1, 0), 1'b1,
				known_result(1'b1, 1'b1, STATUS_DRIVING)},
			'{tick(799, 1500, 1500, 1500, 2000, 1500, 1, 0), 1'b1,
				known_result(1'b0, 1'b0, STATUS_LINK_LOST)},
			'{tick(1500, 1500, 800, 1500, 2000, 1500, 0, 0), 1'b1,
				known_result(1'b0, 1'b0, STATUS_LINK_LOST)},
			'{tick(1500, 1500, 800, 1500, 2000, 2201, 1, 0), 1'b1,
				known_result(1'b0, 1'b0, STATUS_LINK_LOST)},
			'{tick(1500, 1500, 800, 1500, 1501, 1500, 1, 0), 1'b1,
				known_result(1'b1, 1'b1, STATUS_DRIVING)},
			'{tick(1500, 1500, 1200, 1500, 1500, 1500, 1, 0), 1'b1,
				known_result(1'b0, 1'b1, STATUS_LOCKED)},
			'{tick(1500, 1500, 1099, 1500, 2000, 1500, 1, 0), 1'b0, '0},
			'{tick(1000, 1000, 2000, 2000, 2000, 1500, 1, 0), 1'b0, '0}
		};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_tick(directed_rows[i].item, directed_rows[i].known, directed_rows[i].result);

		for (int phase = 0; phase < 10; phase++) begin
			if (phase > 0) begin
				settle();
				case (phase)
					1: apply_settings(2000, 500, 500, SIGN_NEG, SIGN_POS, SIGN_POS, 0, 4095);
					2: apply_settings(1000, 0, 0, SIGN_OFF, SIGN_RAW_MINUS_TWO, SIGN_NEG, 4095, 0);
					3: apply_settings(0, 250, 300, SIGN_RAW_MINUS_TWO, SIGN_POS, SIGN_NEG,
						1500, 1100);
					4: apply_settings(900, 511, 511, SIGN_POS, SIGN_NEG, SIGN_RAW_MINUS_TWO,
						1400, 1600);
					9: apply_settings($urandom_range(0, 4095), $urandom_range(0, 4095),
						$urandom_range(0, 4095), $urandom_range(0, 4095),
						$urandom_range(0, 4095), $urandom_range(0, 4095),
						$urandom_range(0, 4095), $urandom_range(0, 4095));
					default: apply_settings($urandom_range(1000, 2000), $urandom_range(0, 500),
						$urandom_range(0, 500), $urandom_range(0, 3), $urandom_range(0, 3),
						$urandom_range(0, 3), $urandom_range(1200, 1800),
						$urandom_range(1000, 1400));
				endcase
			end
			// result side holds off while ticks keep coming, so both queues fill
			if (phase == 5) hold_req = 1'b1;
			repeat (RANDOM_PER_PHASE) send_tick(random_tick(), 1'b0, '0);
		end

		settle();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0 && awaited_pulses.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* quad_rc_arm_and_mix_core.f */
hw/rtl/qram_pkg.sv
hw/rtl/qram_fifo.sv
hw/rtl/qram_front.sv
hw/rtl/qram_back.sv
hw/rtl/quad_rc_arm_and_mix_core.sv
sim/quad_rc_arm_and_mix_core_test.sv
